### rtl/lagged_fibonacci_int_rng_assert.svh
// assertion macros for the lagged fibonacci generator
// no dependencies; included by the top level only
`ifndef LAGGED_FIBONACCI_INT_RNG_ASSERT_SVH
`define LAGGED_FIBONACCI_INT_RNG_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfr check failed");

// next-cycle implication, checked out of reset
`define LFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfr check failed");

`endif

### rtl/lfr_pkg.sv
// shared constants and types for the lagged fibonacci generator
// no dependencies
package lfr_pkg;

    localparam int LONG_LAG   = 100;
    localparam int SHORT_LAG  = 37;
    localparam int SEPARATION = 70;
    localparam int WORD_BITS  = 30;
    localparam int PREP_LEN   = 2 * LONG_LAG - 1;
    localparam int WARM_STEPS = 10 * PREP_LEN;
    localparam int NEAR_OFF   = LONG_LAG - SHORT_LAG;

    localparam int LEN_W  = 12;
    localparam int KEEP_W = 7;
    localparam int PA_W   = $clog2(PREP_LEN);
    localparam int RA_W   = $clog2(LONG_LAG);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [PA_W-1:0]      t_paddr;
    typedef logic [RA_W-1:0]      t_raddr;

    localparam t_word DEFAULT_SEED = t_word'(314159);

    typedef enum logic {
        CFG_BATCH_LENGTH = 1'b0,
        CFG_KEEP_COUNT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BOOT,
        S_SQR,
        S_SUB,
        S_SHF,
        S_ROT,
        S_LOAD,
        S_WARM,
        S_NRD,
        S_NCAP,
        S_OUT,
        S_STEP
    } t_state;

    typedef struct packed {
        logic  mode;
        t_word seed;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_word value;
        logic  defaulted;
    } t_result;

endpackage

### rtl/lfr_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module lfr_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/lfr_core.sv
// sequencer for seeding, stepping and reading the lag ring
// depends on lfr_pkg and lfr_ram
module lfr_core
    import lfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_item             i_item,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [KEEP_W-1:0] i_keep,
    input  logic              i_out_free,
    output logic              o_idle,
    output t_result           o_res
);

    t_state r_state, n_state;
    logic [1:0]       r_ph, n_ph;
    t_paddr           r_j, n_j;
    t_word            r_s, n_s;
    logic [6:0]       r_t, n_t;
    t_word            r_ss, n_ss;
    t_raddr           r_head, n_head;
    logic [KEEP_W-1:0] r_deliv, n_deliv;
    logic             r_seeded, n_seeded;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_nxt, n_nxt;
    logic             r_def, n_def;
    t_word            r_val, n_val;
    t_word            r_a, n_a;
    t_word            r_b, n_b;

    // memory ports
    logic   p_we, g_we;
    t_paddr p_wa, p_ra, p_rb;
    t_word  p_wd, p_qa, p_qb;
    t_raddr g_wa, g_ra, g_rb;
    t_word  g_wd, g_qa, g_qb;

    lfr_ram #(.WIDTH(WORD_BITS), .DEPTH(PREP_LEN)) u_prep (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr_a(p_ra), .i_raddr_b(p_rb), .o_rdata_a(p_qa), .o_rdata_b(p_qb)
    );

    lfr_ram #(.WIDTH(WORD_BITS), .DEPTH(LONG_LAG)) u_ring (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr_a(g_ra), .i_raddr_b(g_rb), .o_rdata_a(g_qa), .o_rdata_b(g_qb)
    );

    // index arithmetic
    t_paddr     j_x2;
    t_word      seed_pick, ss_init, ss_nx;
    logic [WORD_BITS:0] ss_sh;
    t_raddr     far, head_inc, dcl, pos;
    logic [RA_W:0] psum;
    logic [6:0] t_nx;
    t_word      s_nx;
    logic [KEEP_W-1:0] deliv_inc;

    assign j_x2      = {r_j[PA_W-2:0], 1'b0};
    assign seed_pick = i_item.mode ? DEFAULT_SEED : i_item.seed;
    assign ss_init   = (seed_pick + t_word'(2)) & ~t_word'(1);
    assign ss_sh     = {r_ss, 1'b0};
    assign ss_nx     = ss_sh[WORD_BITS] ? ss_sh[WORD_BITS-1:0] + t_word'(2)
                                        : ss_sh[WORD_BITS-1:0];
    assign far       = (r_head >= t_raddr'(SHORT_LAG)) ? r_head - t_raddr'(SHORT_LAG)
                                                       : r_head + t_raddr'(NEAR_OFF);
    assign head_inc  = (r_head == t_raddr'(LONG_LAG - 1)) ? '0 : r_head + t_raddr'(1);
    assign dcl       = (r_deliv >= KEEP_W'(LONG_LAG)) ? t_raddr'(LONG_LAG - 1)
                                                       : r_deliv[RA_W-1:0];
    assign psum      = {1'b0, r_head} + {1'b0, dcl};
    assign pos       = (psum >= (RA_W+1)'(LONG_LAG)) ? t_raddr'(psum - (RA_W+1)'(LONG_LAG))
                                                     : psum[RA_W-1:0];
    assign deliv_inc = KEEP_W'(dcl) + KEEP_W'(1);
    // end of a square-and-multiply round
    assign s_nx      = r_s >> 1;
    assign t_nx      = (r_s == '0) ? r_t - 7'd1 : r_t;

    // next state and register updates
    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_j      = r_j;
        n_s      = r_s;
        n_t      = r_t;
        n_ss     = r_ss;
        n_head   = r_head;
        n_deliv  = r_deliv;
        n_seeded = r_seeded;
        n_cnt    = r_cnt;
        n_nxt    = r_nxt;
        n_def    = r_def;
        n_val    = r_val;
        n_a      = r_a;
        n_b      = r_b;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_nxt = i_item.mode;
                    if (i_item.mode && r_seeded) begin
                        n_def   = 1'b0;
                        n_state = S_NRD;
                    end else begin
                        n_def   = i_item.mode;
                        n_s     = seed_pick;
                        n_ss    = ss_init;
                        n_j     = '0;
                        n_state = S_BOOT;
                    end
                end
            end
            S_BOOT: begin
                n_ss = ss_nx;
                if (r_j == t_paddr'(LONG_LAG - 1)) begin
                    n_j     = t_paddr'(LONG_LAG - 1);
                    n_t     = 7'(SEPARATION - 1);
                    n_ph    = 2'd0;
                    n_state = S_SQR;
                end else begin
                    n_j = r_j + t_paddr'(1);
                end
            end
            S_SQR: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    if (r_j == t_paddr'(1)) begin
                        n_j     = t_paddr'(PREP_LEN - 1);
                        n_state = S_SUB;
                    end else begin
                        n_j = r_j - t_paddr'(1);
                    end
                end
            end
            S_SUB: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    n_a = p_qa;
                end
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    if (r_j == t_paddr'(LONG_LAG)) begin
                        if (r_s[0]) begin
                            n_j     = t_paddr'(LONG_LAG);
                            n_state = S_SHF;
                        end else begin
                            n_s = (r_s == '0) ? r_s : s_nx;
                            n_t = t_nx;
                            n_j = t_paddr'(LONG_LAG - 1);
                            n_state = (t_nx == '0) ? S_LOAD : S_SQR;
                            if (t_nx == '0) begin
                                n_j = '0;
                            end
                        end
                    end else begin
                        n_j = r_j - t_paddr'(1);
                    end
                end
            end
            S_SHF: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    n_ph = 2'd0;
                    if (r_j == t_paddr'(1)) begin
                        n_state = S_ROT;
                    end else begin
                        n_j = r_j - t_paddr'(1);
                    end
                end
            end
            S_ROT: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    n_a = p_qa;
                    n_b = p_qb;
                end
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    n_s  = s_nx;
                    n_t  = t_nx;
                    if (t_nx == '0) begin
                        n_j     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_j     = t_paddr'(LONG_LAG - 1);
                        n_state = S_SQR;
                    end
                end
            end
            S_LOAD: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    n_ph = 2'd0;
                    if (r_j == t_paddr'(LONG_LAG - 1)) begin
                        n_head  = '0;
                        n_cnt   = '0;
                        n_state = S_WARM;
                    end else begin
                        n_j = r_j + t_paddr'(1);
                    end
                end
            end
            S_WARM, S_STEP: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    n_ph   = 2'd0;
                    n_head = head_inc;
                    n_cnt  = r_cnt + LEN_W'(1);
                    if (r_state == S_WARM && r_cnt == LEN_W'(WARM_STEPS - 1)) begin
                        n_deliv  = '0;
                        n_seeded = 1'b1;
                        n_val    = '0;
                        n_state  = r_nxt ? S_NRD : S_OUT;
                    end else if (r_state == S_STEP && r_cnt == i_len - LEN_W'(1)) begin
                        n_deliv = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_NRD: begin
                n_state = S_NCAP;
            end
            S_NCAP: begin
                n_val   = g_qa;
                n_deliv = deliv_inc;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_ph  = 2'd0;
                    n_cnt = '0;
                    n_state = (r_deliv >= i_keep) ? S_STEP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port and result drive
    always_comb begin
        p_we = 1'b0;
        p_wa = '0;
        p_wd = '0;
        p_ra = '0;
        p_rb = '0;
        g_we = 1'b0;
        g_wa = '0;
        g_wd = '0;
        g_ra = '0;
        g_rb = '0;
        o_res = '0;
        unique case (r_state)
            S_BOOT: begin
                p_we = 1'b1;
                p_wa = r_j;
                p_wd = (r_j == t_paddr'(1)) ? (r_ss | t_word'(1)) : r_ss;
            end
            S_SQR: begin
                p_ra = r_j;
                if (r_ph == 2'd1) begin
                    p_we = 1'b1;
                    p_wa = j_x2;
                    p_wd = p_qa;
                end else if (r_ph == 2'd2) begin
                    p_we = 1'b1;
                    p_wa = j_x2 - t_paddr'(1);
                end
            end
            S_SUB: begin
                if (r_ph == 2'd0) begin
                    p_ra = r_j;
                    p_rb = r_j - t_paddr'(NEAR_OFF);
                end else if (r_ph == 2'd1) begin
                    p_we = 1'b1;
                    p_wa = r_j - t_paddr'(NEAR_OFF);
                    p_wd = p_qb - p_qa;
                    p_ra = r_j - t_paddr'(LONG_LAG);
                end else begin
                    p_we = 1'b1;
                    p_wa = r_j - t_paddr'(LONG_LAG);
                    p_wd = p_qa - r_a;
                end
            end
            S_SHF: begin
                p_ra = r_j - t_paddr'(1);
                if (r_ph == 2'd1) begin
                    p_we = 1'b1;
                    p_wa = r_j;
                    p_wd = p_qa;
                end
            end
            S_ROT: begin
                p_ra = t_paddr'(LONG_LAG);
                p_rb = t_paddr'(SHORT_LAG);
                if (r_ph == 2'd1) begin
                    p_we = 1'b1;
                    p_wd = p_qa;
                end else if (r_ph == 2'd2) begin
                    p_we = 1'b1;
                    p_wa = t_paddr'(SHORT_LAG);
                    p_wd = r_b - r_a;
                end
            end
            S_LOAD: begin
                p_ra = r_j;
                if (r_ph == 2'd1) begin
                    g_we = 1'b1;
                    g_wa = (r_j < t_paddr'(SHORT_LAG)) ? t_raddr'(r_j + t_paddr'(NEAR_OFF))
                                                      : t_raddr'(r_j - t_paddr'(SHORT_LAG));
                    g_wd = p_qa;
                end
            end
            S_WARM, S_STEP: begin
                g_ra = r_head;
                g_rb = far;
                if (r_ph == 2'd1) begin
                    g_we = 1'b1;
                    g_wa = r_head;
                    g_wd = g_qa - g_qb;
                end
            end
            S_NRD, S_NCAP: begin
                g_ra = pos;
            end
            S_OUT: begin
                o_res.valid     = i_out_free;
                o_res.value     = r_val;
                o_res.defaulted = r_def;
            end
            S_IDLE: begin
                o_res = '0;
            end
            default: o_res = '0;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= '0;
            r_head   <= '0;
            r_deliv  <= '0;
            r_seeded <= 1'b0;
            r_cnt    <= '0;
            r_t      <= '0;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_head   <= n_head;
            r_deliv  <= n_deliv;
            r_seeded <= n_seeded;
            r_cnt    <= n_cnt;
            r_t      <= n_t;
        end
        r_j   <= n_j;
        r_s   <= n_s;
        r_ss  <= n_ss;
        r_nxt <= n_nxt;
        r_def <= n_def;
        r_val <= n_val;
        r_a   <= n_a;
        r_b   <= n_b;
    end

endmodule

### rtl/lagged_fibonacci_int_rng.sv
// top level of the subtractive lagged fibonacci generator (lags 100 and 37)
// depends on lfr_pkg, lfr_core and lagged_fibonacci_int_rng_assert.svh
//
// input channel (i_valid / o_ready) takes one word: i_mode 0 seeds with
// i_seed_value, i_mode 1 asks for the next 30-bit value. every word gives
// exactly one result word on the output channel (o_valid / i_ready).
// a seed is acknowledged with value 0. a next word that arrives before any
// seed first seeds with 314159 and flags o_default_seeded.
// a plain next word reads the ring in S_NRD and S_NCAP and offers its result
// in S_OUT; when it closes a batch the ring then steps batch_length times (at
// least 100) before o_ready returns. a seed runs 69 to 99 rounds in the
// 199-word buffer (a shift and a rotate are added when the seed bit is set),
// then the ring load and WARM_STEPS warm-up steps; the buffer ram has a single
// write port.
// the config channel (i_cfg_valid / o_cfg_ready) writes batch_length
// (index 0) or keep_count (index 1); write only while the block is idle.
// reset clears the sequencer, the seeded flag and the output valid flag and
// loads the register defaults; the rams need no clearing.
// a stalled receiver holds the result in the output register; the next input
// word is still taken, and its own result waits behind that one.
module lagged_fibonacci_int_rng
    import lfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [WORD_BITS-1:0] i_seed_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_random_value,
    output logic                 o_default_seeded,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

`include "lagged_fibonacci_int_rng_assert.svh"

    // config registers
    logic [LEN_W-1:0]  r_len;
    logic [KEEP_W-1:0] r_keep;
    logic [LEN_W-1:0]  len_eff;
    logic [KEEP_W-1:0] keep_eff;

    // output register
    logic              r_ovalid;
    t_word             r_oval;
    logic              r_odef;

    logic    core_idle;
    logic    out_free;
    logic    start;
    t_item   item;
    t_result res;

    assign o_cfg_ready = 1'b1;

    // short batches act as one ring length, keep count clamps to 1..100
    assign len_eff  = (r_len < LEN_W'(LONG_LAG)) ? LEN_W'(LONG_LAG) : r_len;
    assign keep_eff = (r_keep == '0) ? KEEP_W'(1)
                    : (r_keep > KEEP_W'(LONG_LAG)) ? KEEP_W'(LONG_LAG) : r_keep;

    assign o_ready   = core_idle;
    assign start     = i_valid && core_idle;
    assign item.mode = i_mode;
    assign item.seed = i_seed_value;
    // the slot frees when empty or when its word leaves this cycle
    assign out_free  = !r_ovalid || i_ready;

    lfr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (item),
        .i_len      (len_eff),
        .i_keep     (keep_eff),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1009);
            r_keep   <= KEEP_W'(LONG_LAG);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BATCH_LENGTH: r_len  <= i_cfg_data;
                    CFG_KEEP_COUNT:   r_keep <= i_cfg_data[KEEP_W-1:0];
                    default:          r_len  <= r_len;
                endcase
            end
            if (res.valid) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (res.valid) begin
            r_oval <= res.value;
            r_odef <= res.defaulted;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_random_value   = r_oval;
    assign o_default_seeded = r_odef;

    // an accepted word keeps the sequencer busy for the next cycle
    `LFR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // the sequencer never overwrites a result that is still waiting
    `LFR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, res.valid, !r_ovalid || i_ready)
    // a result is never offered while the sequencer reports idle
    `LFR_ASSERT_NOW(a_ack_zero, i_clk, i_rst_n, res.valid && core_idle, 1'b0)

endmodule
